// File: src/exposure_shot_sequencer_unit_assert.svh
// Assertion macros for the exposure shot sequencer unit.
// Used by ess_step under src; compiled out when SYNTHESIS is defined.
`ifndef EXPOSURE_SHOT_SEQUENCER_UNIT_ASSERT_SVH
`define EXPOSURE_SHOT_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ESS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ess assertion failed");

// Expression must never be true outside reset.
`define ESS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("ess forbidden condition seen");

`else

`define ESS_ASSERT(lbl, clk, rstn, prop)
`define ESS_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: src/ess_pkg.sv
// Shared types and constants for the exposure shot sequencer.
// No dependencies.
`timescale 1ns / 1ps

package ess_pkg;

  localparam int unsigned ShotWidth = 7;
  localparam int unsigned LenWidth  = 10;
  localparam int unsigned CfgIdxWidth = 2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_TOTAL_SHOTS     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_START_DELAY     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_EXPOSURE_LENGTH = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_PAUSE_LENGTH    = 2'd3;

  // Reset values
  localparam logic [ShotWidth-1:0] RST_TOTAL_SHOTS     = 7'd1;
  localparam logic [LenWidth-1:0]  RST_START_DELAY     = 10'd0;
  localparam logic [LenWidth-1:0]  RST_EXPOSURE_LENGTH = 10'd5;
  localparam logic [LenWidth-1:0]  RST_PAUSE_LENGTH    = 10'd5;

  // Phase codes as reported on the result word
  localparam logic [1:0] PHASE_CODE_STANDBY  = 2'd0;
  localparam logic [1:0] PHASE_CODE_EXPOSURE = 2'd1;
  localparam logic [1:0] PHASE_CODE_WAITING  = 2'd2;

  typedef enum logic [2:0] {
    PH_STANDBY  = 3'b001,
    PH_EXPOSURE = 3'b010,
    PH_WAITING  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ShotWidth-1:0] total_shots;
    logic [LenWidth-1:0]  start_delay;
    logic [LenWidth-1:0]  exposure_length;
    logic [LenWidth-1:0]  pause_length;
  } cfg_t;

  typedef struct packed {
    logic                 finished;
    logic [ShotWidth-1:0] shots_taken;
    logic                 relay_on;
    logic [1:0]           phase;
  } res_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_EXPOSURE: code = PHASE_CODE_EXPOSURE;
      PH_WAITING:  code = PHASE_CODE_WAITING;
      default:     code = PHASE_CODE_STANDBY;
    endcase
    return code;
  endfunction

endpackage

// File: src/exposure_shot_sequencer_unit.sv
// Exposure shot sequencer: one tick word in, one status word out.
// Throughput: one word per cycle while the output side does not stall.
// Stages: tick in register, phase logic, result register.
// A stalled result register holds the input stage; ready follows the output side.
// Reset (rst_ni low, async): standby, relay off, counters zero, registers at defaults.
`timescale 1ns / 1ps

module exposure_shot_sequencer_unit #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] run_enabled
  // status stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [1:0] phase, [2] relay_on,
                                                         // [9:3] shots_taken
  output logic                            m_axis_tlast,  // finished
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ess_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ess_pkg::LenWidth-1:0]    cfg_data_i
);

  ess_pkg::cfg_t cfg;
  ess_pkg::res_t res;
  ess_pkg::res_t out_q;
  logic in_vld_q, in_run_q;
  logic out_vld_q;
  logic advance;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_run_q <= s_axis_tdata[0];
    end
  end

  ess_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ess_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_vld_q && advance),
    .run_i  (in_run_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.shots_taken, out_q.relay_on, out_q.phase};
  assign m_axis_tlast  = out_q.finished;

endmodule

// File: src/ess_cfg_regs.sv
// Configuration register file of the exposure shot sequencer.
// Depends on ess_pkg.
`timescale 1ns / 1ps

module ess_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ess_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [ess_pkg::LenWidth-1:0]        cfg_data_i,
  output ess_pkg::cfg_t                       cfg_o
);

  ess_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ess_pkg::CFG_TOTAL_SHOTS:
          cfg_d.total_shots = cfg_data_i[ess_pkg::ShotWidth-1:0];
        ess_pkg::CFG_START_DELAY:     cfg_d.start_delay     = cfg_data_i;
        ess_pkg::CFG_EXPOSURE_LENGTH: cfg_d.exposure_length = cfg_data_i;
        ess_pkg::CFG_PAUSE_LENGTH:    cfg_d.pause_length    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_shots     <= ess_pkg::RST_TOTAL_SHOTS;
      cfg_q.start_delay     <= ess_pkg::RST_START_DELAY;
      cfg_q.exposure_length <= ess_pkg::RST_EXPOSURE_LENGTH;
      cfg_q.pause_length    <= ess_pkg::RST_PAUSE_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/ess_step.sv
// Phase machine and counters of the exposure shot sequencer; one tick per call.
// Depends on ess_pkg and exposure_shot_sequencer_unit_assert.svh.
`timescale 1ns / 1ps
`include "exposure_shot_sequencer_unit_assert.svh"

module ess_step #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,   // a tick word is consumed this cycle
  input  logic          run_i,    // run_enabled of that word
  input  ess_pkg::cfg_t cfg_i,
  output ess_pkg::res_t res_o     // result after this tick
);

  ess_pkg::phase_e phase_q, phase_d;
  logic [ess_pkg::ShotWidth-1:0] shot_q, shot_d;
  logic [COUNT_WIDTH-1:0] delay_q, delay_d;
  logic [COUNT_WIDTH-1:0] exp_q, exp_d;
  logic [COUNT_WIDTH-1:0] pause_q, pause_d;
  logic relay_q, relay_d;
  logic finished;

  // lengths are taken modulo 2^COUNT_WIDTH
  logic [COUNT_WIDTH-1:0] delay_lim, exp_lim, pause_lim;
  assign delay_lim = COUNT_WIDTH'(cfg_i.start_delay);
  assign exp_lim   = COUNT_WIDTH'(cfg_i.exposure_length);
  assign pause_lim = COUNT_WIDTH'(cfg_i.pause_length);

  always_comb begin
    phase_d  = phase_q;
    shot_d   = shot_q;
    delay_d  = delay_q;
    exp_d    = exp_q;
    pause_d  = pause_q;
    relay_d  = relay_q;
    finished = 1'b0;
    if (run_i) begin
      if (shot_q >= cfg_i.total_shots) begin
        phase_d  = ess_pkg::PH_STANDBY;
        shot_d   = '0;
        finished = 1'b1;
      end else begin
        unique case (phase_q)
          ess_pkg::PH_EXPOSURE: begin
            if (exp_q >= exp_lim) begin
              exp_d   = '0;
              shot_d  = shot_q + 7'd1;
              phase_d = ess_pkg::PH_WAITING;
            end else begin
              exp_d = exp_q + 1'b1;
            end
          end
          ess_pkg::PH_WAITING: begin
            if (pause_q >= pause_lim) begin
              pause_d = '0;
              exp_d   = '0;
              phase_d = ess_pkg::PH_EXPOSURE;
            end else begin
              pause_d = pause_q + 1'b1;
            end
          end
          default: begin
            phase_d = ess_pkg::PH_STANDBY;
            // unmasked zero test on the configured start delay skips the delay
            if (shot_q != '0 || cfg_i.start_delay == '0) begin
              phase_d = ess_pkg::PH_EXPOSURE;
            end else if (delay_q >= delay_lim) begin
              delay_d = '0;
              phase_d = ess_pkg::PH_EXPOSURE;
            end else begin
              delay_d = delay_q + 1'b1;
            end
          end
        endcase
      end
      if (phase_d == ess_pkg::PH_EXPOSURE) begin
        relay_d = 1'b1;
      end else if (phase_d == ess_pkg::PH_STANDBY) begin
        relay_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ess_pkg::PH_STANDBY;
      shot_q  <= '0;
      delay_q <= '0;
      exp_q   <= '0;
      pause_q <= '0;
      relay_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shot_q  <= shot_d;
      delay_q <= delay_d;
      exp_q   <= exp_d;
      pause_q <= pause_d;
      relay_q <= relay_d;
    end
  end

  assign res_o.phase       = ess_pkg::phase_code(phase_d);
  assign res_o.relay_on    = relay_d;
  assign res_o.shots_taken = shot_d;
  assign res_o.finished    = finished;

  `ESS_ASSERT(a_relay_on_in_exposure, clk_i, rst_ni, (phase_q == ess_pkg::PH_EXPOSURE) |-> relay_q)
  `ESS_ASSERT(a_relay_off_in_standby, clk_i, rst_ni, (phase_q == ess_pkg::PH_STANDBY) |-> !relay_q)
  `ESS_ASSERT(a_shot_only_from_exposure, clk_i, rst_ni, ((shot_q != $past(shot_q)) && (shot_q != '0)) |-> $past(phase_q == ess_pkg::PH_EXPOSURE))
  `ESS_ASSERT(a_finish_goes_standby, clk_i, rst_ni, res_o.finished |-> ((res_o.phase == ess_pkg::PHASE_CODE_STANDBY) && !res_o.relay_on && (res_o.shots_taken == '0)))

endmodule
